[src/spot_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spot_pkg
// Shared types and constants for the shape pair overlap test.
// ----------------------------------------------------------------------------
package spot_pkg;

  localparam int COORD_BITS    = 16;
  localparam int FRACTION_BITS = 4;
  // one guard bit for differences, radius sums and truncated integer parts
  localparam int EXT_BITS      = COORD_BITS + 1;
  // a square of an EXT_BITS value never exceeds 2^(2*COORD_BITS)
  localparam int SQ_BITS       = 2 * COORD_BITS + 1;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [EXT_BITS-1:0]   ext_t;
  typedef logic        [SQ_BITS-1:0]    sq_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_POINT  = 2'd1,
    KIND_CIRCLE = 2'd2,
    KIND_RECT   = 2'd3
  } kind_t;

  // pair class after ordering so that the first shape has the lower kind
  typedef enum logic [2:0] {
    PAIR_NONE = 3'd0,
    PAIR_PP   = 3'd1,
    PAIR_PC   = 3'd2,
    PAIR_PR   = 3'd3,
    PAIR_CC   = 3'd4,
    PAIR_CR   = 3'd5,
    PAIR_RR   = 3'd6
  } pair_t;

  typedef struct packed {
    kind_t  kind;
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
  } shape_t;

  typedef struct packed {
    pair_t  pair;
    shape_t a;
    shape_t b;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

[src/spot_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spot_front
// Orders the two shapes by kind and classifies the pair.
// ----------------------------------------------------------------------------
module spot_front (
  input  spot_pkg::shape_t shape_a,
  input  spot_pkg::shape_t shape_b,
  output spot_pkg::entry_t entry
);
  import spot_pkg::*;

  shape_t lo_shape;
  shape_t hi_shape;

  // put the lower kind first; the tests are symmetric
  always_comb begin
    if (shape_a.kind <= shape_b.kind) begin
      lo_shape = shape_a;
      hi_shape = shape_b;
    end else begin
      lo_shape = shape_b;
      hi_shape = shape_a;
    end
  end

  always_comb begin
    entry.a    = lo_shape;
    entry.b    = hi_shape;
    entry.pair = PAIR_NONE;
    unique case ({lo_shape.kind, hi_shape.kind})
      {KIND_POINT,  KIND_POINT}:  entry.pair = PAIR_PP;
      {KIND_POINT,  KIND_CIRCLE}: entry.pair = PAIR_PC;
      {KIND_POINT,  KIND_RECT}:   entry.pair = PAIR_PR;
      {KIND_CIRCLE, KIND_CIRCLE}: entry.pair = PAIR_CC;
      {KIND_CIRCLE, KIND_RECT}:   entry.pair = PAIR_CR;
      {KIND_RECT,   KIND_RECT}:   entry.pair = PAIR_RR;
      default:                    entry.pair = PAIR_NONE;
    endcase
  end

endmodule

[src/spot_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spot_queue
// Short queue of classified pairs between front and back.
// ----------------------------------------------------------------------------
module spot_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  spot_pkg::entry_t      push_data,
  input  logic                  pop,
  output spot_pkg::entry_t      head,
  output spot_pkg::queue_stat_t stat
);
  import spot_pkg::*;

  entry_t               mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_BITS:0]   count_r, count_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign stat.full  = (count_r == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[src/spot_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spot_back
// Four-stage pipeline that carries out the overlap test for each pair.
// ----------------------------------------------------------------------------
module spot_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  spot_pkg::entry_t      head,
  input  spot_pkg::queue_stat_t stat,
  output logic                  pop,
  output logic                  out_valid,
  output logic                  out_overlap
);
  import spot_pkg::*;

  localparam ext_t TRUNC_BIAS = ext_t'((1 << FRACTION_BITS) - 1);

  function automatic coord_t clamp_c(coord_t v, coord_t lo, coord_t hi);
    coord_t res;
    if (v < lo) begin
      res = lo;
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

  // integer part, truncated toward zero
  function automatic ext_t trunc_int(coord_t v);
    ext_t ve;
    ve = ext_t'(v);
    if (v < 0) begin
      ve = ve + TRUNC_BIAS;
    end
    return ve >>> FRACTION_BITS;
  endfunction

  // stage 1: select point, centre and radius; settle the compare-only pairs
  logic   s1_valid_r;
  logic   s1_dist_r;
  logic   s1_hit_r;
  coord_t s1_px_r, s1_py_r, s1_cx_r, s1_cy_r;
  ext_t   s1_rad_r;

  coord_t s1_px_nxt, s1_py_nxt, s1_cx_nxt, s1_cy_nxt;
  ext_t   s1_rad_nxt;
  logic   s1_dist_nxt, s1_hit_nxt;

  // stage 2: differences
  logic s2_valid_r, s2_dist_r, s2_hit_r;
  ext_t s2_dx_r, s2_dy_r, s2_rad_r;

  // stage 3: squares
  logic s3_valid_r, s3_dist_r, s3_hit_r, s3_rneg_r;
  sq_t  s3_sqx_r, s3_sqy_r, s3_sqr_r;

  logic signed [2*EXT_BITS-1:0] prod_x, prod_y, prod_r;
  logic        [SQ_BITS:0]      dist_sum;

  logic out_valid_r, out_overlap_r;

  assign pop = !stat.empty;

  always_comb begin
    s1_px_nxt   = head.a.x1;
    s1_py_nxt   = head.a.y1;
    s1_cx_nxt   = head.b.x1;
    s1_cy_nxt   = head.b.y1;
    s1_rad_nxt  = ext_t'(head.b.x2);
    s1_dist_nxt = 1'b0;
    s1_hit_nxt  = 1'b0;
    unique case (head.pair)
      PAIR_PP: begin
        s1_hit_nxt = (trunc_int(head.a.x1) == trunc_int(head.b.x1)) &&
                     (trunc_int(head.a.y1) == trunc_int(head.b.y1));
      end
      PAIR_PC: begin
        s1_dist_nxt = 1'b1;
      end
      PAIR_PR: begin
        s1_hit_nxt = (head.a.x1 >= head.b.x1) && (head.a.x1 <= head.b.x2) &&
                     (head.a.y1 >= head.b.y1) && (head.a.y1 <= head.b.y2);
      end
      PAIR_CC: begin
        s1_dist_nxt = 1'b1;
        s1_rad_nxt  = ext_t'(head.a.x2) + ext_t'(head.b.x2);
      end
      PAIR_CR: begin
        // clamp the centre into the rectangle, test against the circle
        s1_dist_nxt = 1'b1;
        s1_px_nxt   = clamp_c(head.a.x1, head.b.x1, head.b.x2);
        s1_py_nxt   = clamp_c(head.a.y1, head.b.y1, head.b.y2);
        s1_cx_nxt   = head.a.x1;
        s1_cy_nxt   = head.a.y1;
        s1_rad_nxt  = ext_t'(head.a.x2);
      end
      PAIR_RR: begin
        s1_hit_nxt = (head.b.x1 <= head.a.x2) && (head.a.x1 <= head.b.x2) &&
                     (head.b.y1 <= head.a.y2) && (head.a.y1 <= head.b.y2);
      end
      default: begin
        s1_hit_nxt = 1'b0;
      end
    endcase
  end

  assign prod_x   = s2_dx_r * s2_dx_r;
  assign prod_y   = s2_dy_r * s2_dy_r;
  assign prod_r   = s2_rad_r * s2_rad_r;
  assign dist_sum = {1'b0, s3_sqx_r} + {1'b0, s3_sqy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= !stat.empty;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_px_r   <= s1_px_nxt;
    s1_py_r   <= s1_py_nxt;
    s1_cx_r   <= s1_cx_nxt;
    s1_cy_r   <= s1_cy_nxt;
    s1_rad_r  <= s1_rad_nxt;
    s1_dist_r <= s1_dist_nxt;
    s1_hit_r  <= s1_hit_nxt;

    s2_dx_r   <= ext_t'(s1_px_r) - ext_t'(s1_cx_r);
    s2_dy_r   <= ext_t'(s1_py_r) - ext_t'(s1_cy_r);
    s2_rad_r  <= s1_rad_r;
    s2_dist_r <= s1_dist_r;
    s2_hit_r  <= s1_hit_r;

    s3_sqx_r  <= prod_x[SQ_BITS-1:0];
    s3_sqy_r  <= prod_y[SQ_BITS-1:0];
    s3_sqr_r  <= prod_r[SQ_BITS-1:0];
    s3_rneg_r <= s2_rad_r[EXT_BITS-1];
    s3_dist_r <= s2_dist_r;
    s3_hit_r  <= s2_hit_r;

    if (s3_dist_r) begin
      out_overlap_r <= !s3_rneg_r && (dist_sum <= {1'b0, s3_sqr_r});
    end else begin
      out_overlap_r <= s3_hit_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_overlap = out_overlap_r;

endmodule

[src/shape_pair_overlap_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shape_pair_overlap_test
// Overlap test for a pair of 2D shapes: none, point, circle or rectangle.
// ----------------------------------------------------------------------------
// A pair is transferred at a rising edge where start is high and busy is low.
// The block takes one pair every clock cycle while busy is low. Its result
// appears on out_overlap with out_valid high for exactly one cycle, once the
// pair has passed through the queue and three pipeline stages: select,
// difference, square, with the compare in the output register. Results come
// out in the order the pairs went in. The receiver cannot stall the block:
// the back pipeline drains the queue every cycle, so busy is the queue-full
// flag and stays low in normal running.
// ----------------------------------------------------------------------------
// Coordinates are signed fixed point with spot_pkg::FRACTION_BITS fraction
// bits. Either shape of kind none gives no overlap. Point against point
// compares integer parts truncated toward zero; rectangle bounds are
// inclusive and are used as given, even when inverted. Circle tests compare
// exact squared distances with the squared radius (or radius sum); a
// negative radius (or radius sum) gives no overlap.
// ----------------------------------------------------------------------------
module shape_pair_overlap_test (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_a_kind,
  input  spot_pkg::coord_t          in_a_first_x,
  input  spot_pkg::coord_t          in_a_first_y,
  input  spot_pkg::coord_t          in_a_second_x,
  input  spot_pkg::coord_t          in_a_second_y,
  input  logic [1:0]                in_b_kind,
  input  spot_pkg::coord_t          in_b_first_x,
  input  spot_pkg::coord_t          in_b_first_y,
  input  spot_pkg::coord_t          in_b_second_x,
  input  spot_pkg::coord_t          in_b_second_y,
  output logic                      out_valid,
  output logic                      out_overlap
);
  import spot_pkg::*;

  shape_t      shape_a;
  shape_t      shape_b;
  entry_t      front_entry;
  entry_t      queue_head;
  queue_stat_t queue_stat;
  logic        in_transfer;
  logic        back_pop;

  // gather the input ports into shape records
  always_comb begin
    shape_a.kind = kind_t'(in_a_kind);
    shape_a.x1   = in_a_first_x;
    shape_a.y1   = in_a_first_y;
    shape_a.x2   = in_a_second_x;
    shape_a.y2   = in_a_second_y;
    shape_b.kind = kind_t'(in_b_kind);
    shape_b.x1   = in_b_first_x;
    shape_b.y1   = in_b_first_y;
    shape_b.x2   = in_b_second_x;
    shape_b.y2   = in_b_second_y;
  end

  // hold off new pairs only while the queue is full
  assign busy        = queue_stat.full;
  assign in_transfer = start && !busy;

  // front: order the shapes by kind and classify the pair
  spot_front u_front (
    .shape_a (shape_a),
    .shape_b (shape_b),
    .entry   (front_entry)
  );

  // decouple front from back
  spot_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_transfer),
    .push_data (front_entry),
    .pop       (back_pop),
    .head      (queue_head),
    .stat      (queue_stat)
  );

  // back: advance each classified pair through the test pipeline
  spot_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (queue_head),
    .stat        (queue_stat),
    .pop         (back_pop),
    .out_valid   (out_valid),
    .out_overlap (out_overlap)
  );

endmodule

[dv/shape_pair_overlap_test_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shape_pair_overlap_test_test
// Self-checking bench for the shape pair overlap test.
// ----------------------------------------------------------------------------
// A table of hand-picked shape pairs runs first. It covers every kind pairing,
// kind none, extreme coordinates, touching boundaries, negative radii and
// inverted rectangles. About six hundred random pairs follow. Most are
// clustered so that hits and near misses both turn up, and the rest use raw
// random bits. Pairs go in as bursts with random gaps between them. Every
// result is checked in transfer order, against an in-bench model of the
// overlap rules or, for table rows with a typed-in value, against that value.
// ----------------------------------------------------------------------------
module shape_pair_overlap_test_test;
  import spot_pkg::*;

  localparam int N_DRILL      = 25;
  localparam int N_RANDOM     = 600;
  localparam int N_PAIRS      = N_DRILL + N_RANDOM;
  localparam int DRAIN_CYCLES = 8;      // margin for the pipeline to settle
  localparam int CYCLE_LIMIT  = 100000;

  // One shape as it sits on the ports
  typedef struct packed {
    kind_t  kind;
    coord_t fx;
    coord_t fy;
    coord_t sx;
    coord_t sy;
  } figure_t;

  // How a table row is judged: by the model, or by a value typed in
  typedef enum logic [1:0] {
    BY_PREDICTOR = 2'd0,
    EXPECT_CLEAR = 2'd1,
    EXPECT_HIT   = 2'd2
  } check_t;

  typedef struct {
    figure_t a;
    figure_t b;
    check_t  chk;
  } drill_t;

  typedef struct {
    int   seq;
    logic overlap;
  } verdict_t;

  logic    clk     = 1'b0;
  logic    rst_n   = 1'b0;
  logic    start   = 1'b0;
  figure_t fig_a   = '0;
  figure_t fig_b   = '0;
  check_t  cur_chk = BY_PREDICTOR;
  int      cur_seq = 0;
  logic    busy;
  logic    out_valid;
  logic    out_overlap;

  drill_t   drills [N_DRILL];
  verdict_t awaited[$];
  verdict_t got;
  int       errors      = 0;
  int       results     = 0;
  int       hits        = 0;
  int       cycle_count = 0;

  shape_pair_overlap_test u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_a_kind    (fig_a.kind),
    .in_a_first_x (fig_a.fx),
    .in_a_first_y (fig_a.fy),
    .in_a_second_x(fig_a.sx),
    .in_a_second_y(fig_a.sy),
    .in_b_kind    (fig_b.kind),
    .in_b_first_x (fig_b.fx),
    .in_b_first_y (fig_b.fy),
    .in_b_second_x(fig_b.sx),
    .in_b_second_y(fig_b.sy),
    .out_valid    (out_valid),
    .out_overlap  (out_overlap)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Overlap model
  // --------------------------------------------------------------------------
  // Sign-extend a coordinate so that every sum and square below is exact
  function automatic longint wide(coord_t v);
    return longint'(v);
  endfunction

  // Integer part, truncated toward zero (not floored)
  function automatic longint int_part(longint v);
    return (v < 0) ? -((-v) >>> FRACTION_BITS) : (v >>> FRACTION_BITS);
  endfunction

  function automatic logic reaches(longint dx, longint dy, longint r);
    return (dx * dx + dy * dy) <= r * r;
  endfunction

  function automatic logic point_in_disc(longint px, longint py, figure_t c);
    if (wide(c.sx) < 0) return 1'b0;
    return reaches(px - wide(c.fx), py - wide(c.fy), wide(c.sx));
  endfunction

  // Bounds are inclusive and taken as written, inverted or not
  function automatic logic point_in_box(longint px, longint py, figure_t r);
    return px >= wide(r.fx) && px <= wide(r.sx) && py >= wide(r.fy) && py <= wide(r.sy);
  endfunction

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic overlap_of(figure_t a, figure_t b);
    figure_t lo;
    figure_t hi;
    longint  rsum;
    if (a.kind == KIND_NONE || b.kind == KIND_NONE) return 1'b0;
    // Put the lower kind first; each pairing is then handled once
    if (a.kind <= b.kind) begin
      lo = a;
      hi = b;
    end else begin
      lo = b;
      hi = a;
    end
    if (lo.kind == KIND_POINT && hi.kind == KIND_POINT)
      return int_part(wide(lo.fx)) == int_part(wide(hi.fx)) &&
             int_part(wide(lo.fy)) == int_part(wide(hi.fy));
    if (lo.kind == KIND_POINT && hi.kind == KIND_CIRCLE)
      return point_in_disc(wide(lo.fx), wide(lo.fy), hi);
    if (lo.kind == KIND_POINT && hi.kind == KIND_RECT)
      return point_in_box(wide(lo.fx), wide(lo.fy), hi);
    if (lo.kind == KIND_CIRCLE && hi.kind == KIND_CIRCLE) begin
      rsum = wide(lo.sx) + wide(hi.sx);
      if (rsum < 0) return 1'b0;
      return reaches(wide(lo.fx) - wide(hi.fx), wide(lo.fy) - wide(hi.fy), rsum);
    end
    if (lo.kind == KIND_CIRCLE && hi.kind == KIND_RECT)
      return point_in_disc(clamp_to(wide(lo.fx), wide(hi.fx), wide(hi.sx)),
                           clamp_to(wide(lo.fy), wide(hi.fy), wide(hi.sy)), lo);
    if (lo.kind == KIND_RECT && hi.kind == KIND_RECT)
      return wide(hi.fx) <= wide(lo.sx) && wide(lo.fx) <= wide(hi.sx) &&
             wide(hi.fy) <= wide(lo.sy) && wide(lo.fy) <= wide(hi.sy);
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic figure_t fig(kind_t k, int fx, int fy, int sx, int sy);
    figure_t f;
    f.kind = k;
    f.fx   = coord_t'(fx);
    f.fy   = coord_t'(fy);
    f.sx   = coord_t'(sx);
    f.sy   = coord_t'(sy);
    return f;
  endfunction

  function automatic drill_t row(figure_t a, figure_t b, check_t chk);
    drill_t d;
    d.a   = a;
    d.b   = b;
    d.chk = chk;
    return d;
  endfunction

  function automatic int sat(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Mostly well-formed shapes clustered within +/- span. Now and then use raw
  // bits, a negative radius or an inverted rectangle.
  function automatic figure_t random_figure(int span);
    figure_t f;
    int      cx;
    int      cy;
    int      r;
    coord_t  t;
    f.kind = ($urandom_range(0, 11) == 0) ? KIND_NONE : kind_t'($urandom_range(1, 3));
    f.fx   = coord_t'($urandom());
    f.fy   = coord_t'($urandom());
    f.sx   = coord_t'($urandom());
    f.sy   = coord_t'($urandom());
    if ($urandom_range(0, 4) == 0) return f;
    cx   = int'($urandom_range(0, 2 * span)) - span;
    cy   = int'($urandom_range(0, 2 * span)) - span;
    f.fx = coord_t'(cx);
    f.fy = coord_t'(cy);
    case (f.kind)
      KIND_CIRCLE: begin
        r = int'($urandom_range(0, span));
        if ($urandom_range(0, 7) == 0) r = -r - 1;
        f.sx = coord_t'(r);
      end
      KIND_RECT: begin
        f.sx = coord_t'(sat(cx + int'($urandom_range(0, span))));
        f.sy = coord_t'(sat(cy + int'($urandom_range(0, span))));
        if ($urandom_range(0, 7) == 0) begin
          t    = f.fx;
          f.fx = f.sx;
          f.sx = t;
        end
        if ($urandom_range(0, 7) == 0) begin
          t    = f.fy;
          f.fy = f.sy;
          f.sy = t;
        end
      end
      default: begin
      end
    endcase
    return f;
  endfunction

  function automatic int random_span();
    case ($urandom_range(0, 3))
      0:       return 16;    // integer parts often equal
      1:       return 256;
      2:       return 4096;
      default: return 32767; // full coordinate range
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  initial begin
    drills[0]  = row(fig(KIND_NONE, 0, 0, 0, 0), fig(KIND_NONE, 0, 0, 0, 0),
                     EXPECT_CLEAR);
    drills[1]  = row(fig(KIND_NONE, -32768, -32768, -32768, -32768),
                     fig(KIND_POINT, 32767, 32767, 32767, 32767), EXPECT_CLEAR);
    drills[2]  = row(fig(KIND_RECT, -32768, -32768, 32767, 32767),
                     fig(KIND_NONE, 0, 0, 0, 0), EXPECT_CLEAR);
    // -1.5 and -1.9375 share the integer part -1
    drills[3]  = row(fig(KIND_POINT, -24, 0, 0, 0), fig(KIND_POINT, -31, 0, 0, 0),
                     BY_PREDICTOR);
    // -0.5 and +0.5 both truncate to zero
    drills[4]  = row(fig(KIND_POINT, -8, 8, 0, 0), fig(KIND_POINT, 8, -8, 0, 0),
                     BY_PREDICTOR);
    drills[5]  = row(fig(KIND_POINT, 32767, 32767, 0, 0),
                     fig(KIND_POINT, -32768, -32768, 0, 0), EXPECT_CLEAR);
    // point exactly on the circle, unused point fields all ones
    drills[6]  = row(fig(KIND_POINT, 48, 64, -1, -1), fig(KIND_CIRCLE, 0, 0, 80, 0),
                     BY_PREDICTOR);
    drills[7]  = row(fig(KIND_CIRCLE, 100, 100, -1, 0), fig(KIND_POINT, 100, 100, 0, 0),
                     EXPECT_CLEAR);
    drills[8]  = row(fig(KIND_POINT, -32768, -32768, 0, 0),
                     fig(KIND_CIRCLE, 32767, 32767, 32767, 0), BY_PREDICTOR);
    drills[9]  = row(fig(KIND_CIRCLE, 0, 0, 80, 0), fig(KIND_POINT, 48, 65, 0, 0),
                     BY_PREDICTOR);
    drills[10] = row(fig(KIND_POINT, 10, 20, 0, 0), fig(KIND_RECT, 10, 20, 30, 40),
                     BY_PREDICTOR);
    drills[11] = row(fig(KIND_RECT, 30, 40, 10, 20), fig(KIND_POINT, 20, 30, 0, 0),
                     BY_PREDICTOR);
    drills[12] = row(fig(KIND_RECT, -32768, -32768, 32767, 32767),
                     fig(KIND_POINT, 32767, -32768, 0, 0), EXPECT_HIT);
    drills[13] = row(fig(KIND_CIRCLE, 0, 0, 30, 0), fig(KIND_CIRCLE, 50, 0, 20, 0),
                     BY_PREDICTOR);
    drills[14] = row(fig(KIND_CIRCLE, 0, 0, -10, 0), fig(KIND_CIRCLE, 0, 0, 5, 0),
                     EXPECT_CLEAR);
    // one radius negative, sum still positive
    drills[15] = row(fig(KIND_CIRCLE, 0, 0, -5, 0), fig(KIND_CIRCLE, 10, 0, 20, 0),
                     BY_PREDICTOR);
    drills[16] = row(fig(KIND_CIRCLE, -32768, -32768, 32767, 0),
                     fig(KIND_CIRCLE, 32767, 32767, 32767, 0), BY_PREDICTOR);
    drills[17] = row(fig(KIND_CIRCLE, -32768, -32768, 32767, -32768),
                     fig(KIND_CIRCLE, -32768, -32768, -32768, 32767), EXPECT_CLEAR);
    drills[18] = row(fig(KIND_CIRCLE, 0, 0, 10, 0), fig(KIND_RECT, 5, 5, 100, 100),
                     BY_PREDICTOR);
    drills[19] = row(fig(KIND_RECT, -100, -100, 100, 100), fig(KIND_CIRCLE, 3, -7, 0, 0),
                     BY_PREDICTOR);
    // inverted rectangle: the clamp lands on the first corner, (100, 100)
    drills[20] = row(fig(KIND_CIRCLE, 0, 0, 10, 0), fig(KIND_RECT, 100, 100, -100, -100),
                     BY_PREDICTOR);
    drills[21] = row(fig(KIND_RECT, 0, 0, 10, 10), fig(KIND_CIRCLE, 5, 5, -32768, 0),
                     EXPECT_CLEAR);
    drills[22] = row(fig(KIND_RECT, 0, 0, 10, 10), fig(KIND_RECT, 10, 10, 20, 20),
                     BY_PREDICTOR);
    drills[23] = row(fig(KIND_RECT, -32768, -32768, 32767, 32767),
                     fig(KIND_RECT, 32767, 32767, 32767, 32767), BY_PREDICTOR);
    drills[24] = row(fig(KIND_RECT, 20, 20, 0, 0), fig(KIND_RECT, 5, 5, 15, 15),
                     BY_PREDICTOR);
  end

  // --------------------------------------------------------------------------
  // Sender: bursts of pairs with random gaps, some bursts back to back
  // --------------------------------------------------------------------------
  initial begin : send_pairs
    int      idx;
    int      burst;
    int      gap;
    int      span;
    figure_t na;
    figure_t nb;
    check_t  nchk;
    verdict_t v;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    idx   = 0;
    burst = $urandom_range(1, 20);
    gap   = $urandom_range(0, 3);
    while (idx < N_PAIRS) begin
      @(posedge clk);
      // The ports still hold the values the block saw at this edge
      if (start && !busy) begin
        v.seq     = cur_seq;
        v.overlap = (cur_chk == BY_PREDICTOR) ? overlap_of(fig_a, fig_b)
                                              : (cur_chk == EXPECT_HIT);
        awaited.insert(awaited.size(), v);
        idx++;
      end else if (start) begin
        continue; // hold the pair until the block takes it
      end
      if (idx >= N_PAIRS) begin
        start <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        start <= 1'b0;
      end else begin
        if (idx < N_DRILL) begin
          na   = drills[idx].a;
          nb   = drills[idx].b;
          nchk = drills[idx].chk;
        end else begin
          span = random_span();
          na   = random_figure(span);
          nb   = random_figure(span);
          nchk = BY_PREDICTOR;
        end
        fig_a   <= na;
        fig_b   <= nb;
        cur_chk <= nchk;
        cur_seq <= idx;
        start   <= 1'b1;
        burst--;
        if (burst == 0) begin
          burst = $urandom_range(1, 24);
          gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end

    // Drain: wait for every expected result, then let the pipeline settle
    while (awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d shape pairs (%0d from the table, %0d random) in bursts.",
             N_PAIRS, N_DRILL, N_RANDOM);
    $display("Checked %0d results, %0d of them overlapping; %0d mismatches.",
             results, hits, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result checker: one strobe, one transfer, compared in order
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results++;
      if (out_overlap === 1'b1) hits++;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual overlap %b",
                 $time, out_overlap);
        errors++;
      end else begin
        got = awaited.pop_front();
        if (out_overlap !== got.overlap) begin
          $display("%0t: pair %0d overlap mismatch, expected %b, actual %b",
                   $time, got.seq, got.overlap, out_overlap);
          errors++;
        end
      end
    end
  end

  // Watchdog: stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, awaited.size());
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

[files.f]
src/spot_pkg.sv
src/spot_front.sv
src/spot_queue.sv
src/spot_back.sv
src/shape_pair_overlap_test.sv
dv/shape_pair_overlap_test_test.sv
